>>> rtl/leb_pkg.sv
// ----------------------------------------------------------------------------
// Line edit buffer package
// Shared sizes, key codes, cell control types and the sequencer states.
// ----------------------------------------------------------------------------
package leb_pkg;

  // Character cells in the row; the line never holds more than this.
  localparam int unsigned MAX_LEN = 32;

  // Field widths fixed by the interface.
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned KEY_W    = 8;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned STATUS_W = 2;

  // Key codes.
  localparam logic [KEY_W-1:0] KC_LEFT  = 8'd75;
  localparam logic [KEY_W-1:0] KC_RIGHT = 8'd77;
  localparam logic [KEY_W-1:0] KC_HOME  = 8'd71;
  localparam logic [KEY_W-1:0] KC_END   = 8'd79;
  localparam logic [KEY_W-1:0] KC_DEL   = 8'd83;
  localparam logic [KEY_W-1:0] KC_ENTER = 8'd13;
  localparam logic [KEY_W-1:0] KC_ESC   = 8'd27;
  localparam logic [KEY_W-1:0] KC_BKSP  = 8'd8;
  localparam logic [KEY_W-1:0] PRINT_LO = 8'd32;
  localparam logic [KEY_W-1:0] PRINT_HI = 8'd126;

  // Status codes of a result.
  localparam logic [STATUS_W-1:0] ST_EDIT   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ENTER  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ESCAPE = 2'd2;

  // What every cell does in a cycle.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,  // keep the character
    OP_INSERT = 2'd1,  // open a gap at pos and write ch there
    OP_REMOVE = 2'd2,  // close the gap at pos, tail moves one cell left
    OP_SHIFT  = 2'd3   // whole row moves one cell left toward the output
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_STREAM = 2'b10
  } state_e;

endpackage

>>> rtl/leb_cell.sv
// ----------------------------------------------------------------------------
// Line edit buffer character cell
// Holds one character of the line and takes its neighbor's on a shift.
// ----------------------------------------------------------------------------
module leb_cell (
  input  logic                          clk_i,
  input  logic [leb_pkg::POS_W-1:0]     cell_idx_i,
  input  leb_pkg::cell_ctrl_t           ctrl_i,
  input  logic [leb_pkg::CHAR_W-1:0]    left_char_i,
  input  logic [leb_pkg::CHAR_W-1:0]    right_char_i,
  output logic [leb_pkg::CHAR_W-1:0]    char_o
);

  logic [leb_pkg::CHAR_W-1:0] char_d, char_q;

  always_comb begin
    char_d = char_q;
    case (ctrl_i.op)
      leb_pkg::OP_INSERT: begin
        if (cell_idx_i > ctrl_i.pos) begin
          char_d = left_char_i;
        end else if (cell_idx_i == ctrl_i.pos) begin
          char_d = ctrl_i.ch;
        end
      end
      leb_pkg::OP_REMOVE: begin
        if (cell_idx_i >= ctrl_i.pos) begin
          char_d = right_char_i;
        end
      end
      leb_pkg::OP_SHIFT: char_d = right_char_i;
      default:           char_d = char_q;
    endcase
  end

  // Contents are meaningful only below the line length, so no reset.
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign char_o = char_q;

endmodule

>>> rtl/line_edit_buffer_unit.sv
// ----------------------------------------------------------------------------
// Line edit buffer
// Single-line keystroke editor built on a row of character cells.
// ----------------------------------------------------------------------------
// Usage: each request on the input channel (key_code_i, extended_i) is one
// keystroke. Cursor moves, delete, backspace and printable inserts update the
// line and load one edit status result at the edge that takes the request,
// so it is offered from the next cycle on. Enter or Escape stream the line
// out on the result channel, one character per result, the first one loaded
// once the block has entered streaming, with last_o on the final one; an empty
// line gives one result with a zero character, offered like an edit status.
// The line is then cleared. Codes that mean nothing give no result.
// Finishing a line first enters streaming; then the cell row moves the line one
// cell toward cell 0 for each character sent. An empty line is finished
// without streaming. No new keystroke is taken meanwhile. The result register
// frees the input side: a keystroke is taken while a result waits as long as
// the receiver takes it in the same cycle. When the receiver stalls, the
// result holds and streaming pauses with it. Reset clears the cursor, the
// length and the channel state, and sets the length limit to 32; the
// character cells are not cleared. The limit port (cfg_valid_i, cfg_data_i)
// is always ready; the user writes it only while idle, and the block itself
// does not enforce this.
module line_edit_buffer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [leb_pkg::POS_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [leb_pkg::KEY_W-1:0]       key_code_i,
  input  logic                            extended_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [leb_pkg::STATUS_W-1:0]    status_o,
  output logic [leb_pkg::CHAR_W-1:0]      char_out_o,
  output logic [leb_pkg::INDEX_W-1:0]     char_index_o,
  output logic [leb_pkg::POS_W-1:0]       cursor_pos_o,
  output logic [leb_pkg::POS_W-1:0]       line_length_o,
  output logic                            last_o
);

  localparam int unsigned POS_W = leb_pkg::POS_W;

  // Control state.
  leb_pkg::state_e     state_d, state_q;
  logic [POS_W-1:0]    cursor_d, cursor_q;
  logic [POS_W-1:0]    length_d, length_q;
  logic [POS_W-1:0]    max_len_q;
  logic [POS_W-1:0]    sidx_d, sidx_q;
  logic [leb_pkg::STATUS_W-1:0] fin_st_d, fin_st_q;
  logic                out_valid_d, out_valid_q;

  // Result payload.
  logic [leb_pkg::STATUS_W-1:0] res_st_d, res_st_q;
  logic [leb_pkg::CHAR_W-1:0]   res_ch_d, res_ch_q;
  logic [leb_pkg::INDEX_W-1:0]  res_idx_d, res_idx_q;
  logic [POS_W-1:0]             res_cur_d, res_cur_q;
  logic [POS_W-1:0]             res_len_d, res_len_q;
  logic                         res_last_d, res_last_q;

  leb_pkg::cell_ctrl_t          ctrl;
  logic [leb_pkg::CHAR_W-1:0]   cell_char [leb_pkg::MAX_LEN];

  logic             out_free, accept, load_out, stream_last;
  logic [POS_W:0]   limit;

  // Row of character cells; neighbors beyond either end read as zero.
  for (genvar g = 0; g < leb_pkg::MAX_LEN; g++) begin : g_cell
    logic [leb_pkg::CHAR_W-1:0] left_ch, right_ch;
    if (g == 0) begin : g_first
      assign left_ch = '0;
    end else begin : g_mid_l
      assign left_ch = cell_char[g-1];
    end
    if (g == leb_pkg::MAX_LEN - 1) begin : g_last
      assign right_ch = '0;
    end else begin : g_mid_r
      assign right_ch = cell_char[g+1];
    end
    leb_cell u_cell (
      .clk_i        (clk_i),
      .cell_idx_i   (POS_W'(g)),
      .ctrl_i       (ctrl),
      .left_char_i  (left_ch),
      .right_char_i (right_ch),
      .char_o       (cell_char[g])
    );
  end

  // Limit in force is the register saturated to the number of cells.
  assign limit = ({1'b0, max_len_q} > (POS_W+1)'(leb_pkg::MAX_LEN)) ?
                 (POS_W+1)'(leb_pkg::MAX_LEN) : {1'b0, max_len_q};

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == leb_pkg::S_IDLE) && out_free;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign stream_last = (sidx_q + POS_W'(1)) == length_q;

  always_comb begin
    state_d    = state_q;
    cursor_d   = cursor_q;
    length_d   = length_q;
    sidx_d     = sidx_q;
    fin_st_d   = fin_st_q;
    ctrl.op    = leb_pkg::OP_HOLD;
    ctrl.pos   = cursor_q;
    ctrl.ch    = key_code_i[leb_pkg::CHAR_W-1:0];
    load_out   = 1'b0;
    res_st_d   = leb_pkg::ST_EDIT;
    res_ch_d   = '0;
    res_idx_d  = '0;
    res_cur_d  = '0;
    res_len_d  = '0;
    res_last_d = 1'b1;

    case (state_q)
      leb_pkg::S_IDLE: begin
        if (accept) begin
          if (extended_i) begin
            load_out = 1'b1;
            if (key_code_i == leb_pkg::KC_LEFT) begin
              if (cursor_q != '0) cursor_d = cursor_q - POS_W'(1);
            end else if (key_code_i == leb_pkg::KC_RIGHT) begin
              if (cursor_q < length_q) cursor_d = cursor_q + POS_W'(1);
            end else if (key_code_i == leb_pkg::KC_HOME) begin
              cursor_d = '0;
            end else if (key_code_i == leb_pkg::KC_END) begin
              cursor_d = length_q;
            end else if (key_code_i == leb_pkg::KC_DEL) begin
              if (cursor_q < length_q) begin
                ctrl.op  = leb_pkg::OP_REMOVE;
                length_d = length_q - POS_W'(1);
              end
            end else begin
              load_out = 1'b0;
            end
          end else if (key_code_i == leb_pkg::KC_ENTER ||
                       key_code_i == leb_pkg::KC_ESC) begin
            fin_st_d = (key_code_i == leb_pkg::KC_ENTER) ?
                       leb_pkg::ST_ENTER : leb_pkg::ST_ESCAPE;
            sidx_d   = '0;
            if (length_q == '0) begin
              // Empty line: a single zero result, nothing to stream.
              load_out = 1'b1;
              res_st_d = fin_st_d;
              cursor_d = '0;
            end else begin
              state_d = leb_pkg::S_STREAM;
            end
          end else if (key_code_i == leb_pkg::KC_BKSP) begin
            load_out = 1'b1;
            if (cursor_q != '0) begin
              ctrl.op  = leb_pkg::OP_REMOVE;
              ctrl.pos = cursor_q - POS_W'(1);
              cursor_d = cursor_q - POS_W'(1);
              length_d = length_q - POS_W'(1);
            end
          end else if (key_code_i >= leb_pkg::PRINT_LO &&
                       key_code_i <= leb_pkg::PRINT_HI) begin
            load_out = 1'b1;
            if ({1'b0, length_q} < limit) begin
              ctrl.op  = leb_pkg::OP_INSERT;
              cursor_d = cursor_q + POS_W'(1);
              length_d = length_q + POS_W'(1);
            end
          end
          res_cur_d = cursor_d;
          res_len_d = length_d;
        end
      end
      leb_pkg::S_STREAM: begin
        // Cell 0 always holds the next character; the row moves left.
        if (out_free) begin
          ctrl.op    = leb_pkg::OP_SHIFT;
          load_out   = 1'b1;
          res_st_d   = fin_st_q;
          res_ch_d   = cell_char[0];
          res_idx_d  = sidx_q[leb_pkg::INDEX_W-1:0];
          res_last_d = stream_last;
          sidx_d     = sidx_q + POS_W'(1);
          if (stream_last) begin
            cursor_d = '0;
            length_d = '0;
            state_d  = leb_pkg::S_IDLE;
          end
        end
      end
      default: state_d = leb_pkg::S_IDLE;
    endcase
  end

  assign out_valid_d = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= leb_pkg::S_IDLE;
      cursor_q    <= '0;
      length_q    <= '0;
      max_len_q   <= POS_W'(32);
      sidx_q      <= '0;
      fin_st_q    <= leb_pkg::ST_EDIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      length_q    <= length_d;
      sidx_q      <= sidx_d;
      fin_st_q    <= fin_st_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_st_q   <= res_st_d;
      res_ch_q   <= res_ch_d;
      res_idx_q  <= res_idx_d;
      res_cur_q  <= res_cur_d;
      res_len_q  <= res_len_d;
      res_last_q <= res_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_st_q;
  assign char_out_o    = res_ch_q;
  assign char_index_o  = res_idx_q;
  assign cursor_pos_o  = res_cur_q;
  assign line_length_o = res_len_q;
  assign last_o        = res_last_q;

  // The cursor never passes the end of the line.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cursor_q <= length_q)
    else $error("cursor beyond line length");

  // The line never holds more characters than there are cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   {1'b0, length_q} <= (POS_W+1)'(leb_pkg::MAX_LEN))
    else $error("line length beyond cell count");

  // Streaming only happens with characters left in the row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == leb_pkg::S_STREAM |-> length_q != '0)
    else $error("streaming an empty line");

  // The final streamed character leaves an empty line and an idle block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == leb_pkg::S_STREAM && out_free && stream_last) |=>
                   (state_q == leb_pkg::S_IDLE && length_q == '0 && cursor_q == '0))
    else $error("line not cleared after finish");

endmodule

>>> tb/line_edit_buffer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line edit buffer testbench
// Sends keystroke requests to the editor and predicts every status and
// finished-line result from its own copy of the line, cursor, length and
// length limit. Each result taken is compared field by field with the oldest
// prediction. Both channels stall at random but in the third random phase.
// ----------------------------------------------------------------------------
module line_edit_buffer_unit_tb;

  // Prefix bytes that announce an extended key; on their own they mean nothing.
  localparam logic [leb_pkg::KEY_W-1:0] PREFIX_NUL = 8'd0;
  localparam logic [leb_pkg::KEY_W-1:0] PREFIX_EXT = 8'd224;
  // A code just outside the printable range and two unused extended codes.
  localparam logic [leb_pkg::KEY_W-1:0] CODE_DEL_ASCII = 8'd127;
  localparam logic [leb_pkg::KEY_W-1:0] CODE_UP_ARROW  = 8'd72;
  localparam logic [leb_pkg::KEY_W-1:0] CODE_ALL_ONES  = 8'd255;

  // A finish streams at most MAX_LEN characters, so this covers the tail.
  localparam int unsigned SETTLE_CYCLES = leb_pkg::MAX_LEN + 8;
  // Quiet cycles before a limit write, after the last result has been taken.
  localparam int unsigned EDIT_LATENCY  = 4;
  localparam longint unsigned TIMEOUT_NS = 64'd8_000_000;

  typedef struct packed {
    logic [leb_pkg::STATUS_W-1:0] status;
    logic [leb_pkg::CHAR_W-1:0]   ch;
    logic [leb_pkg::INDEX_W-1:0]  idx;
    logic [leb_pkg::POS_W-1:0]    cur;
    logic [leb_pkg::POS_W-1:0]    len;
    logic                         is_last;
  } edit_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [leb_pkg::POS_W-1:0]    cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [leb_pkg::KEY_W-1:0]    key_code_i = '0;
  logic                         extended_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [leb_pkg::STATUS_W-1:0] status_o;
  logic [leb_pkg::CHAR_W-1:0]   char_out_o;
  logic [leb_pkg::INDEX_W-1:0]  char_index_o;
  logic [leb_pkg::POS_W-1:0]    cursor_pos_o;
  logic [leb_pkg::POS_W-1:0]    line_length_o;
  logic                         last_o;

  line_edit_buffer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .key_code_i    (key_code_i),
    .extended_i    (extended_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .char_out_o    (char_out_o),
    .char_index_o  (char_index_o),
    .cursor_pos_o  (cursor_pos_o),
    .line_length_o (line_length_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  // The predicted editor: its own line, cursor, length and limit register.
  logic [leb_pkg::CHAR_W-1:0] line_text [leb_pkg::MAX_LEN];
  int                         line_cursor = 0;
  int                         line_len = 0;
  logic [leb_pkg::POS_W-1:0]  limit_reg = 6'd32;

  edit_result_t awaited_results [$];

  // Handshake counters that the sending tasks watch to see their request go.
  int unsigned keys_taken = 0;
  int unsigned limit_writes = 0;
  // Requests that caused at least one result; ignored codes are not counted.
  int unsigned effective_keys = 0;
  int unsigned mismatch_count = 0;

  // Idle rates in percent, changed per phase.
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;

  function automatic void push_result(input logic [leb_pkg::STATUS_W-1:0] st,
                                      input logic [leb_pkg::CHAR_W-1:0] ch,
                                      input int idx, input int cur, input int len,
                                      input logic is_last);
    edit_result_t r;
    r.status  = st;
    r.ch      = ch;
    r.idx     = idx[leb_pkg::INDEX_W-1:0];
    r.cur     = cur[leb_pkg::POS_W-1:0];
    r.len     = len[leb_pkg::POS_W-1:0];
    r.is_last = is_last;
    awaited_results.push_back(r);
  endfunction

  // Applies one keystroke to the predicted line and queues what it causes.
  // Returns the number of results queued.
  function automatic int apply_keystroke(input logic [leb_pkg::KEY_W-1:0] key,
                                         input logic ext);
    int lim;
    int i;
    int n;
    logic [leb_pkg::STATUS_W-1:0] st;
    lim = (limit_reg < leb_pkg::MAX_LEN) ? int'(limit_reg) : int'(leb_pkg::MAX_LEN);
    if (ext) begin
      case (key)
        leb_pkg::KC_LEFT: begin
          if (line_cursor > 0) line_cursor--;
        end
        leb_pkg::KC_RIGHT: begin
          if (line_cursor < line_len) line_cursor++;
        end
        leb_pkg::KC_HOME: line_cursor = 0;
        leb_pkg::KC_END:  line_cursor = line_len;
        leb_pkg::KC_DEL: begin
          if (line_cursor < line_len) begin
            for (i = line_cursor; i + 1 < line_len; i++) line_text[i] = line_text[i + 1];
            line_len--;
          end
        end
        default: return 0;
      endcase
    end else if (key == leb_pkg::KC_ENTER || key == leb_pkg::KC_ESC) begin
      st = (key == leb_pkg::KC_ENTER) ? leb_pkg::ST_ENTER : leb_pkg::ST_ESCAPE;
      if (line_len == 0) begin
        push_result(st, '0, 0, 0, 0, 1'b1);
        n = 1;
      end else begin
        for (i = 0; i < line_len; i++) begin
          push_result(st, line_text[i], i, 0, 0, i + 1 == line_len);
        end
        n = line_len;
      end
      line_cursor = 0;
      line_len = 0;
      return n;
    end else if (key == leb_pkg::KC_BKSP) begin
      if (line_cursor > 0) begin
        for (i = line_cursor - 1; i + 1 < line_len; i++) line_text[i] = line_text[i + 1];
        line_len--;
        line_cursor--;
      end
    end else if (key >= leb_pkg::PRINT_LO && key <= leb_pkg::PRINT_HI) begin
      // A full line drops the character but still reports its status.
      if (line_len < lim) begin
        for (i = line_len; i > line_cursor; i--) line_text[i] = line_text[i - 1];
        line_text[line_cursor] = key[leb_pkg::CHAR_W-1:0];
        line_cursor++;
        line_len++;
      end
    end else begin
      return 0;
    end
    push_result(leb_pkg::ST_EDIT, '0, 0, line_cursor, line_len, 1'b1);
    return 1;
  endfunction

  function automatic void compare_field(input string field_name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field_name, want, got);
      mismatch_count++;
    end
  endfunction

  // One monitor for all three channels. Results are checked before a new
  // request is predicted, so a result taken in the same cycle as a request
  // always meets the expectation of an earlier keystroke.
  always @(posedge clk_i) begin
    edit_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result with nothing expected: status %0d char %0d index %0d",
                 status_o, char_out_o, char_index_o);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("status", want.status, status_o);
          compare_field("char_out", want.ch, char_out_o);
          compare_field("char_index", want.idx, char_index_o);
          compare_field("cursor_pos", want.cur, cursor_pos_o);
          compare_field("line_length", want.len, line_length_o);
          compare_field("last", want.is_last, last_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (apply_keystroke(key_code_i, extended_i) != 0) effective_keys++;
        keys_taken++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        limit_reg = cfg_data_i;
        limit_writes++;
      end
    end
  end

  // The receiver decides at every falling edge whether it takes a result.
  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= stall_pct);
  end

  // Sends one keystroke request, after a random gap, and returns at the
  // falling edge after it was taken. Valid stays high when no gap follows,
  // so back-to-back requests never drop valid in between.
  task automatic send_key(input logic [leb_pkg::KEY_W-1:0] key, input logic ext);
    int unsigned seen;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    seen = keys_taken;
    in_valid_i = 1'b1;
    key_code_i = key;
    extended_i = ext;
    do @(negedge clk_i); while (keys_taken == seen);
  endtask

  // Holds the sender back until every predicted result has come out.
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
  endtask

  // The limit is only written while the editor is idle. An ignored code may
  // still be in flight when the queue runs dry, hence the short pause.
  task automatic write_limit(input logic [leb_pkg::POS_W-1:0] value);
    int unsigned seen;
    wait_drained();
    repeat (EDIT_LATENCY) @(negedge clk_i);
    seen = limit_writes;
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(negedge clk_i); while (limit_writes == seen);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_printable();
    logic [leb_pkg::KEY_W-1:0] code;
    code = leb_pkg::KEY_W'($urandom_range(leb_pkg::PRINT_HI, leb_pkg::PRINT_LO));
    send_key(code, 1'b0);
  endtask

  task automatic send_noise();
    logic [leb_pkg::KEY_W-1:0] code;
    code = leb_pkg::KEY_W'($urandom_range(255));
    send_key(code, 1'($urandom_range(1)));
  endtask

  // Mostly printable characters with cursor moves, deletes and backspaces
  // mixed in, so that inserts land in the middle of the line too.
  task automatic type_random_keys(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(15))
        0: send_key(leb_pkg::KC_LEFT, 1'b1);
        1: send_key(leb_pkg::KC_RIGHT, 1'b1);
        2: send_key(leb_pkg::KC_HOME, 1'b1);
        3: send_key(leb_pkg::KC_END, 1'b1);
        4: send_key(leb_pkg::KC_DEL, 1'b1);
        5: send_key(leb_pkg::KC_BKSP, 1'b0);
        default: send_printable();
      endcase
    end
  endtask

  task automatic send_finish();
    send_key($urandom_range(1) ? leb_pkg::KC_ENTER : leb_pkg::KC_ESC, 1'b0);
  endtask

  // Finishing an empty line gives a single result with a zero character.
  task automatic test_empty_line();
    send_key(leb_pkg::KC_ENTER, 1'b0);
    send_key(leb_pkg::KC_ESC, 1'b0);
  endtask

  // Every edit key, with moves past both ends, delete at the end of the line
  // and backspace at its start, which change nothing but still report.
  task automatic test_edit_keys();
    send_key(leb_pkg::PRINT_LO, 1'b0);
    send_key(leb_pkg::PRINT_HI, 1'b0);
    send_key(8'h41, 1'b0);
    send_key(leb_pkg::KC_LEFT, 1'b1);
    send_key(leb_pkg::KC_HOME, 1'b1);
    send_key(leb_pkg::KC_LEFT, 1'b1);
    send_key(leb_pkg::KC_RIGHT, 1'b1);
    send_key(leb_pkg::KC_END, 1'b1);
    send_key(leb_pkg::KC_RIGHT, 1'b1);
    send_key(leb_pkg::KC_DEL, 1'b1);
    send_key(leb_pkg::KC_HOME, 1'b1);
    send_key(leb_pkg::KC_BKSP, 1'b0);
    send_key(leb_pkg::KC_DEL, 1'b1);
    send_key(leb_pkg::KC_ESC, 1'b0);
  endtask

  // Codes that mean nothing give no result; the move that follows shows
  // that the line was left alone.
  task automatic test_ignored_codes();
    send_key(PREFIX_NUL, 1'b0);
    send_key(PREFIX_EXT, 1'b0);
    send_key(CODE_DEL_ASCII, 1'b0);
    send_key(CODE_UP_ARROW, 1'b1);
    send_key(CODE_ALL_ONES, 1'b1);
    send_key(leb_pkg::KC_END, 1'b1);
  endtask

  // A zero limit refuses every insert. Lowering the limit below the current
  // length keeps the text but refuses further inserts.
  task automatic test_limit_extremes();
    write_limit(6'd0);
    send_key(8'h7A, 1'b0);
    write_limit(6'd3);
    send_key(8'h68, 1'b0);
    send_key(8'h69, 1'b0);
    send_key(8'h6A, 1'b0);
    write_limit(6'd1);
    send_key(8'h6B, 1'b0);
    send_key(leb_pkg::KC_ENTER, 1'b0);
  endtask

  // A limit above the row size saturates: the row fills to the last cell,
  // the extra characters are dropped and the finish streams the whole row.
  task automatic test_full_line();
    write_limit(6'd63);
    repeat (leb_pkg::MAX_LEN + 2) send_printable();
    send_key(leb_pkg::KC_ESC, 1'b0);
  endtask

  function automatic logic [leb_pkg::POS_W-1:0] pick_limit();
    case ($urandom_range(6))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd32;
      3: return 6'd63;
      4: return leb_pkg::POS_W'($urandom_range(63, 33));
      default: return leb_pkg::POS_W'($urandom_range(31, 2));
    endcase
  endfunction

  // Mostly complete lines with random content, some long enough to fill the
  // row; now and then a limit change, a full drain, noise, or a line that is
  // left unfinished so that the next one builds on it.
  task automatic test_random_keystrokes(input int unsigned gap_pct,
                                        input int unsigned stall_rate,
                                        input int unsigned target);
    int unsigned start;
    send_gap_pct = gap_pct;
    stall_pct = stall_rate;
    write_limit(pick_limit());
    start = effective_keys;
    while (effective_keys - start < target) begin
      case ($urandom_range(19))
        0: write_limit(pick_limit());
        1: begin
          type_random_keys($urandom_range(6, 1));
          wait_drained();
          send_finish();
        end
        2, 3: repeat ($urandom_range(4, 1)) send_noise();
        4: begin
          type_random_keys($urandom_range(5, 1));
          send_noise();
        end
        5: begin
          type_random_keys($urandom_range(leb_pkg::MAX_LEN + 4, leb_pkg::MAX_LEN - 2));
          send_finish();
        end
        default: begin
          type_random_keys($urandom_range(12, 1));
          send_finish();
        end
      endcase
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_gap_pct = 12;
    stall_pct = 79;
    test_empty_line();
    test_edit_keys();
    test_ignored_codes();
    test_limit_extremes();
    test_full_line();

    test_random_keystrokes(12, 79, 110);
    test_random_keystrokes(79, 12, 110);
    test_random_keystrokes(0, 0, 110);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
